[hw/rtl/cpts_pkg.sv]
package cpts_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COORD_W = 14;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [POS_W-1:0]   MAX_LEN   = 16'hFFFF;
  localparam logic [CNT_W-1:0]   CNT_SAT   = 3'd5;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 3'd4;
  localparam logic [CNT_W-1:0]   CNT_MIN   = 3'd3;
  localparam logic [COORD_W-1:0] RADIX     = 14'd10;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;

  typedef enum logic [1:0] {
    RUN_NONE   = 2'd0,
    RUN_DIGITS = 2'd1,
    RUN_SPACES = 2'd2
  } run_mode_t;

  typedef enum logic [1:0] {
    PEND_IDLE  = 2'd0,
    PEND_COMMA = 2'd1,
    PEND_Y     = 2'd2
  } pend_phase_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   end_pos;
    logic               first_match_res;
  } match_t;

  function automatic logic is_stop(input logic [CHAR_W-1:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      CH_NUL, CH_LF, CH_SPACE, CH_BANG, CH_LPAREN, CH_RPAREN, CH_MINUS,
      CH_DOT, CH_COLON, CH_LT, CH_EQ, CH_GT, CH_AT: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic cnt_ok(input logic [CNT_W-1:0] n);
    return (n >= CNT_MIN) && (n <= CNT_MAX);
  endfunction

endpackage

[hw/rtl/cpts_core.sv]
module cpts_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [cpts_pkg::CHAR_W-1:0] ch,
  input  logic                        last,
  output logic                        match_valid,
  output cpts_pkg::match_t            match
);

  logic [cpts_pkg::POS_W-1:0]   position_r, position_nxt;
  logic [cpts_pkg::POS_W-1:0]   boundary_r, boundary_nxt;
  logic                         prev_stop_r, prev_stop_nxt;
  cpts_pkg::run_mode_t          run_mode_r, run_mode_nxt;
  logic [cpts_pkg::CNT_W-1:0]   run_count_r, run_count_nxt;
  logic [cpts_pkg::COORD_W-1:0] run_value_r, run_value_nxt;
  logic [cpts_pkg::POS_W-1:0]   run_start_r, run_start_nxt;
  logic                         run_prefix_r, run_prefix_nxt;
  cpts_pkg::pend_phase_t        pend_phase_r, pend_phase_nxt;
  logic [cpts_pkg::COORD_W-1:0] pend_x_r, pend_x_nxt;
  logic [cpts_pkg::POS_W-1:0]   pend_start_r, pend_start_nxt;
  logic [cpts_pkg::CNT_W-1:0]   y_count_r, y_count_nxt;
  logic [cpts_pkg::COORD_W-1:0] y_value_r, y_value_nxt;
  logic                         found_any_r, found_any_nxt;

  logic                           digit;
  logic                           stop;
  logic [cpts_pkg::DIGIT_W-1:0]   dval;
  logic [cpts_pkg::COORD_W-1:0]   dext;
  logic                           emit_mid;
  logic                           emit_end;

  assign digit = (ch >= cpts_pkg::CH_ZERO) && (ch <= cpts_pkg::CH_NINE);
  assign stop  = cpts_pkg::is_stop(ch);
  assign dval  = digit ? cpts_pkg::DIGIT_W'(ch - cpts_pkg::CH_ZERO) : '0;
  assign dext  = cpts_pkg::COORD_W'(dval);

  always_comb begin
    position_nxt   = position_r;
    boundary_nxt   = boundary_r;
    prev_stop_nxt  = prev_stop_r;
    run_mode_nxt   = run_mode_r;
    run_count_nxt  = run_count_r;
    run_value_nxt  = run_value_r;
    run_start_nxt  = run_start_r;
    run_prefix_nxt = run_prefix_r;
    pend_phase_nxt = pend_phase_r;
    pend_x_nxt     = pend_x_r;
    pend_start_nxt = pend_start_r;
    y_count_nxt    = y_count_r;
    y_value_nxt    = y_value_r;
    found_any_nxt  = found_any_r;
    emit_mid       = 1'b0;
    emit_end       = 1'b0;
    match          = '0;

    // pending pair
    unique case (pend_phase_r)
      cpts_pkg::PEND_COMMA: begin
        if (digit) begin
          pend_phase_nxt = cpts_pkg::PEND_Y;
          y_count_nxt    = cpts_pkg::CNT_W'(1);
          y_value_nxt    = dext;
        end else if (ch != cpts_pkg::CH_SPACE) begin
          pend_phase_nxt = cpts_pkg::PEND_IDLE;
        end
      end
      cpts_pkg::PEND_Y: begin
        if (digit) begin
          if (y_count_r < cpts_pkg::CNT_SAT) begin
            y_count_nxt = y_count_r + cpts_pkg::CNT_W'(1);
            if (y_count_r < cpts_pkg::CNT_MAX) begin
              y_value_nxt = cpts_pkg::COORD_W'(y_value_r * cpts_pkg::RADIX + dext);
            end
          end
        end else if (cpts_pkg::cnt_ok(y_count_r) && (y_value_r != '0) && stop) begin
          emit_mid              = 1'b1;
          match.x_coord         = pend_x_r;
          match.y_coord         = y_value_r;
          match.start_pos       = pend_start_r;
          match.end_pos         = position_r;
          match.first_match_res = !found_any_r;
          found_any_nxt         = 1'b1;
          boundary_nxt          = position_r;
          pend_phase_nxt        = cpts_pkg::PEND_IDLE;
        end else begin
          pend_phase_nxt = cpts_pkg::PEND_IDLE;
        end
      end
      default: pend_phase_nxt = cpts_pkg::PEND_IDLE;
    endcase

    // comma judges the run in front of it as X
    if (ch == cpts_pkg::CH_COMMA) begin
      pend_phase_nxt = cpts_pkg::PEND_IDLE;
      if ((run_mode_r != cpts_pkg::RUN_NONE) && cpts_pkg::cnt_ok(run_count_r) &&
          run_prefix_r && (run_value_r != '0) && (run_start_r >= boundary_nxt)) begin
        pend_phase_nxt = cpts_pkg::PEND_COMMA;
        pend_x_nxt     = run_value_r;
        pend_start_nxt = run_start_r;
      end
    end

    // digit run
    if (digit) begin
      if (run_mode_r == cpts_pkg::RUN_DIGITS) begin
        if (run_count_r < cpts_pkg::CNT_SAT) begin
          run_count_nxt = run_count_r + cpts_pkg::CNT_W'(1);
          if (run_count_r < cpts_pkg::CNT_MAX) begin
            run_value_nxt = cpts_pkg::COORD_W'(run_value_r * cpts_pkg::RADIX + dext);
          end
        end
      end else begin
        run_mode_nxt   = cpts_pkg::RUN_DIGITS;
        run_count_nxt  = cpts_pkg::CNT_W'(1);
        run_value_nxt  = dext;
        run_start_nxt  = position_r;
        run_prefix_nxt = prev_stop_r;
      end
    end else if (ch == cpts_pkg::CH_SPACE) begin
      if (run_mode_r == cpts_pkg::RUN_DIGITS) begin
        run_mode_nxt = cpts_pkg::RUN_SPACES;
      end
    end else begin
      run_mode_nxt = cpts_pkg::RUN_NONE;
    end
    if (emit_mid) begin
      run_mode_nxt = cpts_pkg::RUN_NONE;
    end

    prev_stop_nxt = stop;
    if (position_r < cpts_pkg::MAX_LEN) begin
      position_nxt = position_r + cpts_pkg::POS_W'(1);
    end

    // end of message: flush a Y that runs to the end, then start afresh
    if (last) begin
      if (!emit_mid && (pend_phase_nxt == cpts_pkg::PEND_Y) &&
          cpts_pkg::cnt_ok(y_count_nxt) && (y_value_nxt != '0)) begin
        emit_end              = 1'b1;
        match.x_coord         = pend_x_nxt;
        match.y_coord         = y_value_nxt;
        match.start_pos       = pend_start_nxt;
        match.end_pos         = position_nxt;
        match.first_match_res = !found_any_nxt;
      end
      position_nxt   = '0;
      boundary_nxt   = '0;
      prev_stop_nxt  = 1'b1;
      run_mode_nxt   = cpts_pkg::RUN_NONE;
      run_count_nxt  = '0;
      run_value_nxt  = '0;
      run_start_nxt  = '0;
      run_prefix_nxt = 1'b0;
      pend_phase_nxt = cpts_pkg::PEND_IDLE;
      pend_x_nxt     = '0;
      pend_start_nxt = '0;
      y_count_nxt    = '0;
      y_value_nxt    = '0;
      found_any_nxt  = 1'b0;
    end
  end

  assign match_valid = emit_mid || emit_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      boundary_r   <= '0;
      prev_stop_r  <= 1'b1;
      run_mode_r   <= cpts_pkg::RUN_NONE;
      run_count_r  <= '0;
      run_value_r  <= '0;
      run_start_r  <= '0;
      run_prefix_r <= 1'b0;
      pend_phase_r <= cpts_pkg::PEND_IDLE;
      pend_x_r     <= '0;
      pend_start_r <= '0;
      y_count_r    <= '0;
      y_value_r    <= '0;
      found_any_r  <= 1'b0;
    end else if (step) begin
      position_r   <= position_nxt;
      boundary_r   <= boundary_nxt;
      prev_stop_r  <= prev_stop_nxt;
      run_mode_r   <= run_mode_nxt;
      run_count_r  <= run_count_nxt;
      run_value_r  <= run_value_nxt;
      run_start_r  <= run_start_nxt;
      run_prefix_r <= run_prefix_nxt;
      pend_phase_r <= pend_phase_nxt;
      pend_x_r     <= pend_x_nxt;
      pend_start_r <= pend_start_nxt;
      y_count_r    <= y_count_nxt;
      y_value_r    <= y_value_nxt;
      found_any_r  <= found_any_nxt;
    end
  end

endmodule

[hw/rtl/coordinate_pair_text_scanner_unit.sv]
// Scans a message one character per transaction and reports each "X,Y" pair of
// 3 or 4 digit nonzero values, with boundary checks, start/end positions and a
// first-match flag; in_last closes the message and clears all scan state. One
// character is taken every cycle unless the output stalls: a character is held
// in the input register, then the scan state and result register are updated
// together when it advances out of that register. The only stall is a result
// left waiting in the output register while out_ready is low; positions
// saturate at 65535.
module coordinate_pair_text_scanner_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cpts_pkg::CHAR_W-1:0]    in_ch,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cpts_pkg::COORD_W-1:0]   out_x_coord,
  output logic [cpts_pkg::COORD_W-1:0]   out_y_coord,
  output logic [cpts_pkg::POS_W-1:0]     out_start_pos,
  output logic [cpts_pkg::POS_W-1:0]     out_end_pos,
  output logic                           out_first_match_res
);

  logic                        s1_valid_r;
  logic [cpts_pkg::CHAR_W-1:0] s1_ch_r;
  logic                        s1_last_r;
  logic                        out_valid_r;
  cpts_pkg::match_t            out_r;
  logic                        advance;
  logic                        match_valid;
  cpts_pkg::match_t            match;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  cpts_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .ch          (s1_ch_r),
    .last        (s1_last_r),
    .match_valid (match_valid),
    .match       (match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= match_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && match_valid) begin
      out_r <= match;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_x_coord         = out_r.x_coord;
  assign out_y_coord         = out_r.y_coord;
  assign out_start_pos       = out_r.start_pos;
  assign out_end_pos         = out_r.end_pos;
  assign out_first_match_res = out_r.first_match_res;

endmodule

[hw/rtl/cpts_checker.sv]
module cpts_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cpts_pkg::COORD_W-1:0] out_x_coord,
  input logic [cpts_pkg::COORD_W-1:0] out_y_coord,
  input logic [cpts_pkg::POS_W-1:0]   out_start_pos,
  input logic [cpts_pkg::POS_W-1:0]   out_end_pos
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x_coord) &&
      $stable(out_y_coord) && $stable(out_start_pos) && $stable(out_end_pos))
    else $error("result changed while stalled");

  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_coord != '0) && (out_y_coord != '0) &&
      (out_x_coord <= 14'd9999) && (out_y_coord <= 14'd9999))
    else $error("coordinate out of range");

  a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_end_pos >= out_start_pos)
    else $error("end position before start position");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a character two cycles before");

endmodule

bind coordinate_pair_text_scanner_unit cpts_checker u_cpts_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_x_coord   (out_x_coord),
  .out_y_coord   (out_y_coord),
  .out_start_pos (out_start_pos),
  .out_end_pos   (out_end_pos)
);

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpts_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [CHAR_W-1:0]    in_ch;
  logic                 in_last;
  logic                 out_valid;
  logic                 out_ready;
  logic [COORD_W-1:0]   out_x_coord;
  logic [COORD_W-1:0]   out_y_coord;
  logic [POS_W-1:0]     out_start_pos;
  logic [POS_W-1:0]     out_end_pos;
  logic                 out_first_match_res;

  coordinate_pair_text_scanner_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_ch               (in_ch),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_x_coord         (out_x_coord),
    .out_y_coord         (out_y_coord),
    .out_start_pos       (out_start_pos),
    .out_end_pos         (out_end_pos),
    .out_first_match_res (out_first_match_res)
  );

  always #6 clk = ~clk;

  // scanner state as the block should hold it
  logic [POS_W-1:0]   sc_pos;
  logic [POS_W-1:0]   sc_bound;
  logic               sc_prev_stop;
  run_mode_t          sc_run_mode;
  logic [CNT_W-1:0]   sc_run_cnt;
  logic [COORD_W-1:0] sc_run_val;
  logic [POS_W-1:0]   sc_run_start;
  logic               sc_prefix_ok;
  pend_phase_t        sc_phase;
  logic [COORD_W-1:0] sc_pend_x;
  logic [POS_W-1:0]   sc_pend_start;
  logic [CNT_W-1:0]   sc_y_cnt;
  logic [COORD_W-1:0] sc_y_val;
  logic               sc_found;

  match_t             pending_matches[$];
  int                 mismatches = 0;
  bit                 gaps_on = 1'b0;
  bit                 stall_on = 1'b0;
  logic [CHAR_W-1:0]  msg_bytes[$];
  logic [CHAR_W-1:0]  stop_set [13] = '{CH_NUL, CH_LF, CH_SPACE, CH_BANG, CH_LPAREN,
                                         CH_RPAREN, CH_MINUS, CH_DOT, CH_COLON, CH_LT,
                                         CH_EQ, CH_GT, CH_AT};

  function automatic logic stop_char(input logic [CHAR_W-1:0] c);
    return c inside {CH_NUL, CH_LF, CH_SPACE, CH_BANG, CH_LPAREN, CH_RPAREN, CH_MINUS,
                     CH_DOT, CH_COLON, CH_LT, CH_EQ, CH_GT, CH_AT};
  endfunction

  function automatic logic digits_fit(input logic [CNT_W-1:0] n);
    return (n >= CNT_MIN) && (n <= CNT_MAX);
  endfunction

  task automatic scan_clear();
    sc_pos        = '0;
    sc_bound      = '0;
    sc_prev_stop  = 1'b1;
    sc_run_mode   = RUN_NONE;
    sc_run_cnt    = '0;
    sc_run_val    = '0;
    sc_run_start  = '0;
    sc_prefix_ok  = 1'b0;
    sc_phase      = PEND_IDLE;
    sc_pend_x     = '0;
    sc_pend_start = '0;
    sc_y_cnt      = '0;
    sc_y_val      = '0;
    sc_found      = 1'b0;
  endtask

  task automatic close_pair(input logic [POS_W-1:0] end_at, output match_t m);
    m.x_coord         = sc_pend_x;
    m.y_coord         = sc_y_val;
    m.start_pos       = sc_pend_start;
    m.end_pos         = end_at;
    m.first_match_res = !sc_found;
    sc_found          = 1'b1;
    sc_bound          = end_at;
    sc_phase          = PEND_IDLE;
  endtask

  task automatic scan_char(input logic [CHAR_W-1:0] c, input logic fin,
                           output logic hit, output match_t m);
    logic             dig;
    logic [3:0]       d;
    logic [POS_W-1:0] p;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d   = dig ? 4'(c - CH_ZERO) : 4'd0;
    p   = sc_pos;
    hit = 1'b0;
    m   = '0;

    case (sc_phase)
      PEND_COMMA: begin
        if (dig) begin
          sc_phase = PEND_Y;
          sc_y_cnt = 3'd1;
          sc_y_val = COORD_W'(d);
        end else if (c != CH_SPACE) begin
          sc_phase = PEND_IDLE;
        end
      end
      PEND_Y: begin
        if (dig) begin
          if (sc_y_cnt < CNT_SAT) begin
            sc_y_cnt = sc_y_cnt + 3'd1;
            if (sc_y_cnt <= CNT_MAX) sc_y_val = sc_y_val * RADIX + COORD_W'(d);
          end
        end else if (digits_fit(sc_y_cnt) && sc_y_val != '0 && stop_char(c)) begin
          close_pair(p, m);
          hit = 1'b1;
        end else begin
          sc_phase = PEND_IDLE;
        end
      end
      default: sc_phase = PEND_IDLE;
    endcase

    // a comma decides whether the run before it can be X
    if (c == CH_COMMA) begin
      sc_phase = PEND_IDLE;
      if (sc_run_mode != RUN_NONE && digits_fit(sc_run_cnt) && sc_prefix_ok &&
          sc_run_val != '0 && sc_run_start >= sc_bound) begin
        sc_phase      = PEND_COMMA;
        sc_pend_x     = sc_run_val;
        sc_pend_start = sc_run_start;
      end
    end

    if (dig) begin
      if (sc_run_mode == RUN_DIGITS) begin
        if (sc_run_cnt < CNT_SAT) begin
          sc_run_cnt = sc_run_cnt + 3'd1;
          if (sc_run_cnt <= CNT_MAX) sc_run_val = sc_run_val * RADIX + COORD_W'(d);
        end
      end else begin
        sc_run_mode  = RUN_DIGITS;
        sc_run_cnt   = 3'd1;
        sc_run_val   = COORD_W'(d);
        sc_run_start = p;
        sc_prefix_ok = sc_prev_stop;
      end
    end else if (c == CH_SPACE) begin
      if (sc_run_mode == RUN_DIGITS) sc_run_mode = RUN_SPACES;
    end else begin
      sc_run_mode = RUN_NONE;
    end
    if (hit) sc_run_mode = RUN_NONE;

    sc_prev_stop = stop_char(c);
    if (sc_pos != MAX_LEN) sc_pos = sc_pos + 16'd1;

    if (fin) begin
      if (!hit && sc_phase == PEND_Y && digits_fit(sc_y_cnt) && sc_y_val != '0) begin
        close_pair(sc_pos, m);
        hit = 1'b1;
      end
      scan_clear();
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    logic   hit;
    match_t m;
    match_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        scan_char(in_ch, in_last, hit, m);
        if (hit) pending_matches.push_back(m);
      end
      if (out_valid && out_ready) begin
        if (pending_matches.size() == 0) begin
          $display("%0t: unexpected match, expected none actual x=%0d y=%0d start=%0d end=%0d",
                   $time, out_x_coord, out_y_coord, out_start_pos, out_end_pos);
          mismatches++;
        end else begin
          want = pending_matches.pop_front();
          check_field("x_coord", want.x_coord, out_x_coord);
          check_field("y_coord", want.y_coord, out_y_coord);
          check_field("start_pos", want.start_pos, out_start_pos);
          check_field("end_pos", want.end_pos, out_end_pos);
          check_field("first_match_res", want.first_match_res, out_first_match_res);
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int hold;
    int r;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!stall_on) begin
        out_ready <= 1'b1;
      end else if (r < 6) begin
        hold = $urandom_range(4, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= (r >= 30);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // entered and left at a falling edge
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
    int gap;
    in_valid <= 1'b1;
    in_ch    <= c;
    in_last  <= fin;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) send_char(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic test_valid_pairs();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    send_text("1234,5678", 1'b1);
    send_text("(100, 200) 300 , 400!", 1'b1);
    send_text("001,001 9999,9999", 1'b1);
    drain();
  endtask

  task automatic test_rejected_pairs();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    send_text("12345,678 123,45678 000,123 123,0000 a123,456 123,456a x", 1'b1);
    // pending pair broken by a second comma, which then opens a new pair
    send_text("111, 222,333 ", 1'b1);
    send_char(CH_NUL, 1'b0);
    send_text("456,789", 1'b0);
    send_char(CH_NUL, 1'b1);
    drain();
  endtask

  task automatic test_long_message();
    gaps_on  = 1'b0;
    stall_on = 1'b1;
    repeat (300) send_char("x", 1'b0);
    send_text(" 123,456 222,333", 1'b1);
    drain();
  endtask

  function automatic void add_run(input int n, input bit zeros);
    repeat (n) msg_bytes.push_back(zeros ? CH_ZERO : CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic int run_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(3, 4);
    return $urandom_range(1, 6);
  endfunction

  function automatic void add_spaces();
    repeat ($urandom_range(0, 2)) msg_bytes.push_back(CH_SPACE);
  endfunction

  function automatic void build_message();
    int r;
    msg_bytes.delete();
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        add_run(run_len(), $urandom_range(0, 19) == 0);
        add_spaces();
        msg_bytes.push_back(CH_COMMA);
        add_spaces();
        add_run(run_len(), $urandom_range(0, 19) == 0);
      end else if (r < 72) begin
        add_run(run_len(), 1'b0);
      end else if (r < 82) begin
        msg_bytes.push_back(CH_COMMA);
      end else begin
        repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
      r = $urandom_range(0, 99);
      if (r < 80) msg_bytes.push_back(stop_set[$urandom_range(0, 12)]);
      else if (r < 92) msg_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
      else msg_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) == 0) void'(msg_bytes.pop_back());
  endfunction

  task automatic test_random_messages();
    int sent;
    sent = 0;
    while (sent < 1125) begin
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      build_message();
      foreach (msg_bytes[i]) send_char(msg_bytes[i], i == msg_bytes.size() - 1);
      sent += msg_bytes.size();
    end
    drain();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_ch    = '0;
    in_last  = 1'b0;
    scan_clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_valid_pairs();
    test_rejected_pairs();
    test_long_message();
    test_random_messages();
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
